// File: hw/rtl/lodls_pkg.sv
`timescale 1ns / 1ps

package lodls_pkg;

    localparam int MAX_LEVELS  = 8;
    localparam int DIST_BITS   = 24;

    localparam int PCT_W       = 7;
    localparam int LC_W        = 4;
    localparam int IDX_W       = 3;
    localparam int D2_W        = 48;
    localparam int SQ_W        = D2_W / 2;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int CMP_W       = $clog2(MAX_LEVELS + 1) + 4;

    // margin = floor(diff * pct / 100) via an exact reciprocal
    localparam int PROD_W      = DIST_BITS + PCT_W;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam logic [63:0] RECIP = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam int RECIP_W     = $clog2(RECIP + 64'd1);
    localparam int MUL_W0      = (PROD_W > RECIP_W) ? PROD_W : RECIP_W;
    localparam int MUL_W       = (MUL_W0 > SQ_W) ? MUL_W0 : SQ_W;

    localparam int M_W         = DIST_BITS + 1;
    localparam int T_W         = DIST_BITS + 2;
    localparam int TE_W        = (T_W > SQ_W + 1) ? T_W : SQ_W + 1;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_PCT   = 2'd2;
    localparam logic [PCT_W-1:0]     SCENE_PCT_RESET = 7'd10;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef struct packed {
        logic [PCT_W-1:0]     pct;
        logic                 own;
        logic [DIST_BITS-1:0] distance;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

endpackage

// File: hw/rtl/lod_level_select_hysteresis.sv
`timescale 1ns / 1ps
// A load item gives no result.
// A select walks the levels, passing over skipped ones; each checked level (at most three
// are checked) runs the margin steps only with hysteresis on, then a square and compare.
// These steps share a single multiplier and the single table read port.
// A new item is taken while a result waits in the output register.
// Synchronous active-low reset clears control and config; the table is undefined until loaded.

module lod_level_select_hysteresis
    import lodls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [23:0]           i_entry_distance,
    input  logic                  i_entry_own_hysteresis,
    input  logic [PCT_W-1:0]      i_entry_percent,
    input  logic [IDX_W-1:0]      i_previous_level,
    input  logic [D2_W-1:0]       i_distance_squared,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_chosen_level
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_CUR, S_NEXT, S_MUL1, S_MUL2, S_MUL3, S_THR, S_SQ, S_CMP, S_DONE
    } t_state;

    t_state                r_state;
    logic [LC_W-1:0]       r_level_count;
    logic                  r_hyst_en;
    logic [PCT_W-1:0]      r_scene_pct;

    logic [CMP_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_prev;
    logic [D2_W-1:0]       r_d2;
    logic [LVL_W-1:0]      r_lvl;
    logic [DIST_BITS-1:0]  r_cur;
    logic [DIST_BITS-1:0]  r_next;
    logic [PCT_W-1:0]      r_pct;
    logic                  r_minus;
    logic [M_W-1:0]        r_margin;
    logic                  r_big;
    logic [SQ_W-1:0]       r_tsq;
    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_level;

    logic                  in_xfer;
    logic                  ram_we;
    logic                  ram_re;
    logic [LVL_W-1:0]      ram_raddr;
    t_entry                ram_wdata;
    t_entry                ram_rdata;
    t_mul_req              mul_req;
    logic [2*MUL_W-1:0]    mul_prod;

    logic [CMP_W-1:0]      lvl_c;
    logic [CMP_W-1:0]      prev_c;
    logic [CMP_W-1:0]      lc_c;
    logic                  chk_plus;
    logic                  chk_minus;
    logic                  skip;
    logic                  last;
    logic                  exceed;
    logic [DIST_BITS-1:0]  diff;
    logic [T_W-1:0]        thr;
    logic [TE_W-1:0]       thr_e;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign ram_we = in_xfer && (i_op == OP_LOAD)
                    && (CMP_W'(i_entry_index) < CMP_W'(MAX_LEVELS));
    assign ram_wdata.distance = DIST_BITS'(i_entry_distance);
    assign ram_wdata.own      = i_entry_own_hysteresis;
    assign ram_wdata.pct      = i_entry_percent;

    lodls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEVELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (LVL_W'(i_entry_index)),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lodls_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    always_comb begin
        lvl_c     = CMP_W'(r_lvl);
        prev_c    = CMP_W'(r_prev);
        lc_c      = CMP_W'(r_level_count);
        chk_plus  = (lvl_c == prev_c) || (lvl_c == prev_c + CMP_W'(1));
        chk_minus = (lvl_c + CMP_W'(1) == prev_c);
        skip      = !chk_plus && !chk_minus;
        // advancing past this level ends the walk at the last valid level
        last      = (lvl_c + CMP_W'(2) >= r_count);
        exceed    = r_big || (mul_prod[D2_W-1:0] > r_d2);
        diff      = (r_next >= r_cur) ? (r_next - r_cur) : (r_cur - r_next);

        if (!r_minus) begin
            thr = T_W'(r_next) + T_W'(r_margin);
        end else if (M_W'(r_next) >= r_margin) begin
            thr = T_W'(M_W'(r_next) - r_margin);
        end else begin
            thr = T_W'(r_margin - M_W'(r_next));
        end
        thr_e = TE_W'(thr);

        unique case (r_state)
            S_RD0: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            S_CUR: begin
                ram_re    = 1'b1;
                ram_raddr = LVL_W'(1);
            end
            S_NEXT: begin
                ram_re    = skip && !last;
                ram_raddr = LVL_W'(lvl_c + CMP_W'(2));
            end
            S_CMP: begin
                ram_re    = !exceed && !last;
                ram_raddr = LVL_W'(lvl_c + CMP_W'(2));
            end
            default: begin
                ram_re    = 1'b0;
                ram_raddr = '0;
            end
        endcase

        unique case (r_state)
            S_MUL1: begin
                mul_req.a = MUL_W'(diff);
                mul_req.b = MUL_W'(r_pct);
            end
            S_MUL2: begin
                mul_req.a = MUL_W'(mul_prod[PROD_W-1:0]);
                mul_req.b = MUL_W'(RECIP);
            end
            S_SQ: begin
                mul_req.a = MUL_W'(r_tsq);
                mul_req.b = MUL_W'(r_tsq);
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_level_count <= '0;
            r_hyst_en     <= 1'b0;
            r_scene_pct   <= SCENE_PCT_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[LC_W-1:0];
                    CFG_HYST_ENABLE: r_hyst_en     <= i_cfg_data[0];
                    CFG_SCENE_PCT:   r_scene_pct   <= i_cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end

            // post a finished select, or drop the result once it is transferred
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_op == OP_SELECT) begin
                        r_prev  <= i_previous_level;
                        r_d2    <= i_distance_squared;
                        r_count <= (lc_c > CMP_W'(MAX_LEVELS)) ? CMP_W'(MAX_LEVELS) : lc_c;
                        r_lvl   <= '0;
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_CUR;
                end
                S_CUR: begin
                    r_cur <= ram_rdata.distance;
                    if (r_count <= CMP_W'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_next  <= ram_rdata.distance;
                    r_pct   <= ram_rdata.own ? ram_rdata.pct : r_scene_pct;
                    r_minus <= chk_minus && !chk_plus;
                    if (skip) begin
                        // pass over this level without a check
                        r_cur <= ram_rdata.distance;
                        r_lvl <= LVL_W'(lvl_c + CMP_W'(1));
                        if (last) begin
                            r_state <= S_DONE;
                        end
                    end else if (r_hyst_en) begin
                        r_state <= S_MUL1;
                    end else begin
                        r_margin <= '0;
                        r_state  <= S_THR;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_margin <= M_W'(mul_prod >> RECIP_SHIFT);
                    r_state  <= S_THR;
                end
                S_THR: begin
                    r_big   <= |thr_e[TE_W-1:SQ_W];
                    r_tsq   <= thr_e[SQ_W-1:0];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (exceed) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= r_next;
                        r_lvl <= LVL_W'(lvl_c + CMP_W'(1));
                        if (last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_level <= IDX_W'(r_lvl);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_level = r_out_level;

    a_table_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("table written during a walk");

    a_check_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (CMP_W'(r_lvl) + CMP_W'(1) < r_count))
        else $error("level checked beyond the last valid level");

    a_done_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_lvl == '0 || CMP_W'(r_lvl) < r_count))
        else $error("chosen level outside the table");

    a_margin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL3) |-> ($past(r_state) == S_MUL2))
        else $error("margin taken without its reciprocal step");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished select not posted to the output");

endmodule

// File: hw/rtl/lodls_ram.sv
`timescale 1ns / 1ps

module lodls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lodls_mul.sv
`timescale 1ns / 1ps

module lodls_mul
    import lodls_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic [2*MUL_W-1:0] o_prod
);

    logic [2*MUL_W-1:0] r_prod;

    // registered product, shared by the margin and square steps
    always_ff @(posedge i_clk) begin
        r_prod <= {{MUL_W{1'b0}}, i_req.a} * {{MUL_W{1'b0}}, i_req.b};
    end

    assign o_prod = r_prod;

endmodule
